// ===== rtl/psin_pkg.sv =====
// Shared types and constants for the isotropic point-set normalizer.
package psin_pkg;

   localparam int COORD_W = 12;
   localparam int INDEX_W = 5;
   localparam logic [31:0] SQRT2_Q30 = 32'd1518500250;
   localparam logic RESULT_TRANSFORM = 1'b0;
   localparam logic RESULT_POINT     = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic               final_point;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [31:0]        scale_q;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic [INDEX_W-1:0] point_index;
      logic               degenerate;
      logic               last_result;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD, ST_RD, ST_MX, ST_MY, ST_UY, ST_SQX, ST_SQY, ST_SQ0, ST_SQRT, ST_ACC,
      ST_NN, ST_NUM, ST_SCL, ST_SDONE, ST_OX, ST_OXD, ST_OY, ST_OYD, ST_OYS, ST_TOUT,
      ST_NX, ST_NXD, ST_NY, ST_NYD, ST_NYS, ST_POUT, ST_DIV
   } state_type;

endpackage

// ===== rtl/point_set_isotropic_normalizer_unit.sv =====
// Isotropic point-set normalizer: load, distance sum, scale, transform and point results.
//
// Usage: send points on req (req_valid/req_stall, payload req_data). Points are taken
// and stored one per cycle; a request with final_point set closes the set.
// Points beyond MAX_POINTS are dropped, but their final mark still closes the set.
// After the final request req_stall stays high until the last result is loaded
// into the result register.
// Results leave on rsp (rsp_valid/rsp_stall, payload rsp_data): one transform result
// (scale Q2.30, offsets Q16.16), then one result per stored point in load order
// (Q8.24), the last one flagged by last_result.
// Sequence: the distance pass runs each point through the bit-serial square root, whose
// width follows from SW (COORD_BITS plus count width). The scale and two offsets take
// three passes of the restoring divider (DW = 59 quotient bits at the defaults), and
// each point result takes two divider passes.
// A stalled receiver holds the result register and the sequencer waits on it.
// Reset (synchronous) empties the set, drops any pending result and returns to
// loading; the point store needs no clearing.
module point_set_isotropic_normalizer_unit #(
   parameter int MAX_POINTS = 32,
   parameter int COORD_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psin_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psin_pkg::rsp_type rsp_data
);
   import psin_pkg::*;

   localparam int CW  = COORD_BITS;
   localparam int NW  = $clog2(MAX_POINTS + 1);
   localparam int IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int SW  = CW + NW;
   localparam int PRW = 32 + SW;
   localparam int RW  = SW + 9;
   localparam int AW  = RW + NW;
   localparam int DVW = (AW > NW + 14) ? AW : NW + 14;
   localparam int DW  = PRW + 9;
   localparam int DCW = $clog2(DW + 1);
   localparam int QCW = $clog2(RW + 1);

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [2*CW-1:0] mem [MAX_POINTS];
   logic [2*CW-1:0] rd_ff;

   logic [NW-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]   sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic            pass_ff, pass_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic            deg_ff, deg_in;
   logic [SW-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic            negx_ff, negx_in, negy_ff, negy_in;
   logic [2*SW-1:0] sqx_ff, sqx_in;
   logic [31:0]     scale_ff, scale_in;
   logic [31:0]     offx_ff, offx_in, offy_ff, offy_in;
   logic [31:0]     nx_ff, nx_in, ny_ff, ny_in;

   logic [31:0]     mul_a;
   logic [SW-1:0]   mul_b;
   logic [PRW-1:0]  mul_p_ff;

   logic [2*RW-1:0] rad_ff, rad_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [QCW-1:0]  sqc_ff, sqc_in;
   logic [RW+2:0]   sq_tmp, sq_trial;
   logic            sq_ge;

   logic [DW-1:0]   dq_ff, dq_in;
   logic [DVW-1:0]  dd_ff, dd_in, dr_ff, dr_in;
   logic [DCW-1:0]  dc_ff, dc_in;
   logic [DVW:0]    dv_tmp;
   logic            dv_ge;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            req_take, out_free, last_idx;
   logic [CW-1:0]   in_x, in_y;
   logic [SW:0]     diff;
   logic [SW-1:0]   diff_mag;
   logic [31:0]     q_scale, q_pos, q_neg;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = (NW'(idx_ff) == cnt_ff - NW'(1));
   assign in_x      = CW'(req_data.coord_x);
   assign in_y      = CW'(req_data.coord_y);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // n*coord minus the sum: sign and magnitude
   always_comb begin
      if (state_ff == ST_MY) begin
         diff = {1'b0, mul_p_ff[SW-1:0]} - {1'b0, sumx_ff};
      end else begin
         diff = {1'b0, mul_p_ff[SW-1:0]} - {1'b0, sumy_ff};
      end
      diff_mag = diff[SW] ? SW'(-diff) : diff[SW-1:0];
   end

   assign sq_tmp   = {rem_ff[RW:0], rad_ff[2*RW-1:2*RW-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = (sq_tmp >= sq_trial);

   assign dv_tmp = {dr_ff, dq_ff[DW-1]};
   assign dv_ge  = (dv_tmp >= {1'b0, dd_ff});

   assign q_scale = (|dq_ff[DW-1:32]) ? 32'hFFFF_FFFF : dq_ff[31:0];
   assign q_pos   = (|dq_ff[DW-1:31]) ? 32'h7FFF_FFFF : dq_ff[31:0];
   assign q_neg   = (|dq_ff[DW-1:31]) ? 32'h8000_0000 : 32'(-dq_ff[31:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  if (req_take && req_data.final_point) state_in = ST_RD;
         ST_RD:    state_in = ST_MX;
         ST_MX:    state_in = ST_MY;
         ST_MY:    state_in = ST_UY;
         ST_UY:    state_in = pass_ff ? ST_NX : ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SQ0;
         ST_SQ0:   state_in = ST_SQRT;
         ST_SQRT:  if (sqc_ff == QCW'(1)) state_in = ST_ACC;
         ST_ACC:   state_in = last_idx ? ST_NN : ST_RD;
         ST_NN:    state_in = (acc_ff == '0) ? ST_TOUT : ST_NUM;
         ST_NUM:   state_in = ST_SCL;
         ST_SCL:   state_in = ST_DIV;
         ST_SDONE: state_in = ST_OX;
         ST_OX:    state_in = ST_OXD;
         ST_OXD:   state_in = ST_DIV;
         ST_OY:    state_in = ST_OYD;
         ST_OYD:   state_in = ST_DIV;
         ST_OYS:   state_in = ST_TOUT;
         ST_TOUT:  if (out_free) state_in = ST_RD;
         ST_NX:    state_in = deg_ff ? ST_POUT : ST_NXD;
         ST_NXD:   state_in = ST_DIV;
         ST_NY:    state_in = ST_NYD;
         ST_NYD:   state_in = ST_DIV;
         ST_NYS:   state_in = ST_POUT;
         ST_POUT:  if (out_free) state_in = last_idx ? ST_LOAD : ST_RD;
         ST_DIV:   if (dc_ff == DCW'(1)) state_in = ret_ff;
         default:  state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in = cnt_ff;   sumx_in = sumx_ff; sumy_in = sumy_ff;
      idx_in = idx_ff;   pass_in = pass_ff; acc_in = acc_ff;   deg_in = deg_ff;
      ax_in = ax_ff;     ay_in = ay_ff;     negx_in = negx_ff; negy_in = negy_ff;
      sqx_in = sqx_ff;   scale_in = scale_ff;
      offx_in = offx_ff; offy_in = offy_ff; nx_in = nx_ff;     ny_in = ny_ff;
      rad_in = rad_ff;   rem_in = rem_ff;   root_in = root_ff; sqc_in = sqc_ff;
      dq_in = dq_ff;     dd_in = dd_ff;     dr_in = dr_ff;     dc_in = dc_ff;
      ret_in = ret_ff;
      mul_a = 32'(cnt_ff);
      mul_b = SW'(rd_ff[2*CW-1:CW]);
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (cnt_ff < NW'(MAX_POINTS)) begin
                  cnt_in  = cnt_ff + NW'(1);
                  sumx_in = sumx_ff + SW'(in_x);
                  sumy_in = sumy_ff + SW'(in_y);
               end
               idx_in  = '0;
               pass_in = 1'b0;
               acc_in  = '0;
            end
         end
         ST_MY: begin
            ax_in   = diff_mag;
            negx_in = diff[SW];
            mul_b   = SW'(rd_ff[CW-1:0]);
         end
         ST_UY: begin
            ay_in   = diff_mag;
            negy_in = diff[SW];
         end
         ST_SQX: begin
            mul_a = 32'(ax_ff);
            mul_b = ax_ff;
         end
         ST_SQY: begin
            sqx_in = mul_p_ff[2*SW-1:0];
            mul_a  = 32'(ay_ff);
            mul_b  = ay_ff;
         end
         ST_SQ0: begin
            rad_in  = (2*RW)'({(2*SW+1)'(sqx_ff) + (2*SW+1)'(mul_p_ff[2*SW-1:0]), 16'b0});
            rem_in  = '0;
            root_in = '0;
            sqc_in  = QCW'(RW);
         end
         ST_SQRT: begin
            rad_in = {rad_ff[2*RW-3:0], 2'b00};
            sqc_in = sqc_ff - QCW'(1);
            if (sq_ge) begin
               rem_in  = (RW+2)'(sq_tmp - sq_trial);
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = (RW+2)'(sq_tmp);
               root_in = {root_ff[RW-2:0], 1'b0};
            end
         end
         ST_ACC: begin
            acc_in = acc_ff + AW'(root_ff);
            idx_in = last_idx ? '0 : idx_ff + IW'(1);
         end
         ST_NN: begin
            // clear the transform; flag a degenerate set (all points coincide)
            deg_in   = (acc_ff == '0);
            scale_in = '0;
            offx_in  = '0;
            offy_in  = '0;
            mul_b    = SW'(cnt_ff);
         end
         ST_NUM: begin
            mul_a = SQRT2_Q30;
            mul_b = mul_p_ff[SW-1:0];
         end
         ST_SCL: begin
            dq_in  = (DW'(mul_p_ff) << 8) + DW'(acc_ff >> 1);
            dd_in  = DVW'(acc_ff);
            dr_in  = '0;
            dc_in  = DCW'(DW);
            ret_in = ST_SDONE;
         end
         ST_SDONE: scale_in = q_scale;
         ST_OX: begin
            mul_a = scale_ff;
            mul_b = sumx_ff;
         end
         ST_OXD, ST_OYD: begin
            dq_in  = DW'(mul_p_ff) + (DW'(cnt_ff) << 13);
            dd_in  = DVW'(cnt_ff) << 14;
            dr_in  = '0;
            dc_in  = DCW'(DW);
            ret_in = (state_ff == ST_OXD) ? ST_OY : ST_OYS;
         end
         ST_OY: begin
            offx_in = q_neg;
            mul_a   = scale_ff;
            mul_b   = sumy_ff;
         end
         ST_OYS: offy_in = q_neg;
         ST_TOUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = RESULT_TRANSFORM;
               rsp_in.scale_q     = scale_ff;
               rsp_in.offset_x    = offx_ff;
               rsp_in.offset_y    = offy_ff;
               rsp_in.norm_x      = '0;
               rsp_in.norm_y      = '0;
               rsp_in.point_index = '0;
               rsp_in.degenerate  = deg_ff;
               rsp_in.last_result = 1'b0;
               pass_in            = 1'b1;
               idx_in             = '0;
            end
         end
         ST_NX: begin
            nx_in = '0;
            ny_in = '0;
            mul_a = scale_ff;
            mul_b = ax_ff;
         end
         ST_NXD, ST_NYD: begin
            dq_in  = DW'(mul_p_ff) + (DW'(cnt_ff) << 5);
            dd_in  = DVW'(cnt_ff) << 6;
            dr_in  = '0;
            dc_in  = DCW'(DW);
            ret_in = (state_ff == ST_NXD) ? ST_NY : ST_NYS;
         end
         ST_NY: begin
            nx_in = negx_ff ? q_neg : q_pos;
            mul_a = scale_ff;
            mul_b = ay_ff;
         end
         ST_NYS: ny_in = negy_ff ? q_neg : q_pos;
         ST_POUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = RESULT_POINT;
               rsp_in.scale_q     = '0;
               rsp_in.offset_x    = '0;
               rsp_in.offset_y    = '0;
               rsp_in.norm_x      = nx_ff;
               rsp_in.norm_y      = ny_ff;
               rsp_in.point_index = INDEX_W'(idx_ff);
               rsp_in.degenerate  = deg_ff;
               rsp_in.last_result = last_idx;
               if (last_idx) begin
                  // set done: empty it for the next run
                  cnt_in  = '0;
                  sumx_in = '0;
                  sumy_in = '0;
                  pass_in = 1'b0;
                  idx_in  = '0;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         ST_DIV: begin
            dc_in = dc_ff - DCW'(1);
            dq_in = {dq_ff[DW-2:0], dv_ge};
            dr_in = dv_ge ? DVW'(dv_tmp - {1'b0, dd_ff}) : DVW'(dv_tmp);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
         idx_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sumx_ff      <= sumx_in;
         sumy_ff      <= sumy_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      acc_ff   <= acc_in;
      deg_ff   <= deg_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      sqx_ff   <= sqx_in;
      scale_ff <= scale_in;
      offx_ff  <= offx_in;
      offy_ff  <= offy_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      mul_p_ff <= PRW'(mul_a) * PRW'(mul_b);
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      sqc_ff   <= sqc_in;
      dq_ff    <= dq_in;
      dd_ff    <= dd_in;
      dr_ff    <= dr_in;
      dc_ff    <= dc_in;
      rsp_ff   <= rsp_in;
   end

   // point store
   always_ff @(posedge clock) begin
      if (req_take && (cnt_ff < NW'(MAX_POINTS))) begin
         mem[cnt_ff[IW-1:0]] <= {in_x, in_y};
      end
      rd_ff <= mem[idx_ff];
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MAX_POINTS))
      else $error("point count above capacity");

   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.final_point |=> req_stall)
      else $error("still loading after final request");

   a_transform_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == RESULT_TRANSFORM) |-> !rsp_data.last_result)
      else $error("transform result flagged last");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> (rsp_data.scale_q == '0) &&
      (rsp_data.norm_x == '0) && (rsp_data.norm_y == '0))
      else $error("degenerate set with nonzero values");

   a_empty_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !rsp_valid_ff && rsp_in.last_result |=> (cnt_ff == '0))
      else $error("set not cleared after last result");
`endif

endmodule
